// ===== rtl/multichannel_manchester_frame_decoder_core_macros.svh =====
// assertion macros for the multichannel manchester frame decoder
// used by rtl modules that carry concurrent assertions; expects clk_i and rst_ni
`ifndef MULTICHANNEL_MANCHESTER_FRAME_DECODER_CORE_MACROS_SVH
`define MULTICHANNEL_MANCHESTER_FRAME_DECODER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define MMFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MMFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mmfd_pkg.sv =====
// shared types and constants of the multichannel manchester frame decoder
// no dependencies; imported by the core and the testbench
`default_nettype none

package mmfd_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned CHECK_W    = 4;
  localparam int unsigned BITS_W     = 6;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // frame length limits
  localparam logic [LEN_W-1:0] LEN_MIN   = 6'd1;
  localparam logic [LEN_W-1:0] LEN_MAX   = 6'd32;
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

  // check bits above this weight vanish mod 16
  localparam logic [BITS_W-1:0] CHECK_WEIGHTS = 6'd4;

  // register map, index is paddr[2]
  localparam logic REG_DATA_BITS = 1'b0;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_NONE   = 2'd0,
    STATUS_WORD   = 2'd1,
    STATUS_FAILED = 2'd2
  } status_e;

  // one result item
  typedef struct packed {
    status_e             status;
    logic [WORD_W-1:0]   word;
    logic [SAMPLE_W-1:0] good_mask;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/multichannel_manchester_frame_decoder_core.sv =====
// multichannel manchester frame decoder: per-channel header, data and check tracking
// depends on mmfd_pkg and multichannel_manchester_frame_decoder_core_macros.svh
//
// usage
//   input channel: in_valid_i / in_stall_o carry channel_samples_i, one half-bit
//   sample of every receiver channel per request. output channel: out_valid_o /
//   out_stall_i carry status_o, word_o and good_mask_o. every input request
//   produces exactly one output request.
//   config: apb port, one register data_bits at byte address 0 (payload length,
//   0 acts as 1, above 32 acts as 32). pready is always high.
//   result: registered in the output register, or in the skid register while the
//   output register is full. throughput: one request per cycle while in_stall_o
//   is low; all channels update side by side in one pass of combinational logic
//   between the channel state and the output register.
//   stall: a two-entry output stage (output register plus skid register) keeps
//   accepting while one result waits; in_stall_o rises only when both are full.
//   reset: all channels enabled, header mode, data_bits 32, output empty.
//   after a decoded word or a total failure every channel restarts in header mode.
`default_nettype none

module multichannel_manchester_frame_decoder_core
  import mmfd_pkg::*;
#(
  parameter int unsigned CHANNELS         = 12,
  parameter int unsigned HEADER_HALF_BITS = 20,
  parameter int unsigned CHECK_BITS       = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [SAMPLE_W-1:0]   channel_samples_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 status_o,
  output logic [WORD_W-1:0]          word_o,
  output logic [SAMPLE_W-1:0]        good_mask_o,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int unsigned HC_W = $clog2(HEADER_HALF_BITS + 1);

  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_CHECK  = 2'd2
  } mode_e;

  // configuration register
  logic [LEN_W-1:0] data_bits_q;
  logic [LEN_W-1:0] frame_len;

  // global state
  mode_e                mode_q, mode_d;
  logic [CHECK_W-1:0]   fail_count_q, fail_count_d;
  logic [CHANNELS-1:0]  chan_enable_q, chan_enable_d;

  // per-channel state
  logic [HC_W-1:0]      half_count_q  [CHANNELS];
  logic [HC_W-1:0]      half_count_d  [CHANNELS];
  logic [BITS_W-1:0]    bits_left_q   [CHANNELS];
  logic [BITS_W-1:0]    bits_left_d   [CHANNELS];
  logic                 first_half_q  [CHANNELS];
  logic                 first_half_d  [CHANNELS];
  logic [WORD_W-1:0]    payload_q     [CHANNELS];
  logic [WORD_W-1:0]    payload_d     [CHANNELS];
  logic [CHECK_W-1:0]   ones_count_q  [CHANNELS];
  logic [CHECK_W-1:0]   ones_count_d  [CHANNELS];
  logic [CHECK_W-1:0]   check_value_q [CHANNELS];
  logic [CHECK_W-1:0]   check_value_d [CHANNELS];

  // step results
  logic [CHANNELS-1:0]  samples;
  logic [CHANNELS-1:0]  drop;
  logic [CHANNELS-1:0]  good;
  logic [WORD_W-1:0]    good_word;
  logic                 to_check;
  logic                 to_data;
  logic                 any_on;
  logic                 restart;
  logic [POS_W-1:0]     pos;
  logic [BITS_W-1:0]    sh;
  result_t              result_d;

  // output stage
  logic                 accept;
  logic                 out_fire;
  logic                 out_valid_q;
  logic                 skid_valid_q;
  result_t              out_q;
  result_t              skid_q;

  // handshakes
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign word_o      = out_q.word;
  assign good_mask_o = out_q.good_mask;

  // apb register access
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DATA_BITS) ? APB_DATA_W'(data_bits_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q <= LEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DATA_BITS)) begin
      data_bits_q <= pwdata[LEN_W-1:0];
    end
  end

  // clamp the payload length
  always_comb begin
    if (data_bits_q < LEN_MIN) begin
      frame_len = LEN_MIN;
    end else if (data_bits_q > LEN_MAX) begin
      frame_len = LEN_MAX;
    end else begin
      frame_len = data_bits_q;
    end
  end

  // channels above the sample field read zero
  assign samples = CHANNELS'(channel_samples_i);

  // per-channel step, all channels side by side
  always_comb begin
    half_count_d  = half_count_q;
    bits_left_d   = bits_left_q;
    first_half_d  = first_half_q;
    payload_d     = payload_q;
    ones_count_d  = ones_count_q;
    check_value_d = check_value_q;
    drop          = '0;
    good          = '0;
    good_word     = '0;
    to_check      = 1'b0;
    to_data       = 1'b0;
    pos           = '0;
    sh            = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (chan_enable_q[k]) begin
        case (mode_q)
          MODE_DATA, MODE_CHECK: begin
            if (half_count_q[k] == '0) begin
              half_count_d[k] = HC_W'(1);
              first_half_d[k] = samples[k];
            end else begin
              half_count_d[k] = '0;
              if (samples[k] != first_half_q[k]) begin
                if (mode_q == MODE_DATA) begin
                  pos = POS_W'(frame_len - bits_left_q[k]);
                  payload_d[k] = payload_q[k] | (WORD_W'(samples[k]) << pos);
                  if (!first_half_q[k]) begin
                    ones_count_d[k] = ones_count_q[k] + CHECK_W'(1);
                  end
                end else begin
                  sh = bits_left_q[k] - BITS_W'(1);
                  if (samples[k] && (sh < CHECK_WEIGHTS)) begin
                    check_value_d[k] = check_value_q[k] + (CHECK_W'(1) << sh[1:0]);
                  end
                end
                bits_left_d[k] = bits_left_q[k] - BITS_W'(1);
              end else begin
                drop[k] = 1'b1;
              end
            end
            // end of payload or check field
            if (bits_left_d[k] == '0) begin
              half_count_d[k] = '0;
              if (mode_q == MODE_DATA) begin
                to_check         = 1'b1;
                bits_left_d[k]   = BITS_W'(CHECK_BITS);
                check_value_d[k] = '0;
              end else begin
                if (CHECK_W'(check_value_d[k] + ones_count_d[k]) == '0) begin
                  good[k]   = 1'b1;
                  good_word = payload_d[k];
                end
                bits_left_d[k] = frame_len;
              end
            end
          end
          default: begin
            // header: count zero half-bits
            if (!samples[k]) begin
              half_count_d[k] = half_count_q[k] + HC_W'(1);
            end else begin
              drop[k]         = 1'b1;
              half_count_d[k] = '0;
            end
            if (half_count_d[k] == HC_W'(HEADER_HALF_BITS)) begin
              to_data          = 1'b1;
              half_count_d[k]  = '0;
              bits_left_d[k]   = frame_len;
              payload_d[k]     = '0;
              ones_count_d[k]  = '0;
              check_value_d[k] = '0;
            end
          end
        endcase
      end
    end
  end

  // global next state and result
  always_comb begin
    chan_enable_d = chan_enable_q & ~drop;
    any_on        = |chan_enable_d;
    restart       = !any_on || (|good);
    fail_count_d  = fail_count_q + CHECK_W'($countones(drop));
    if (to_check) begin
      mode_d = MODE_CHECK;
    end else if (to_data) begin
      mode_d = MODE_DATA;
    end else begin
      mode_d = mode_q;
    end
    if (!any_on) begin
      result_d.status    = STATUS_FAILED;
      result_d.word      = '0;
      result_d.good_mask = '0;
    end else if (|good) begin
      result_d.status    = STATUS_WORD;
      result_d.word      = good_word;
      result_d.good_mask = SAMPLE_W'(good);
    end else begin
      result_d.status    = STATUS_NONE;
      result_d.word      = '0;
      result_d.good_mask = '0;
    end
  end

  // channel state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_HEADER;
      fail_count_q  <= '0;
      chan_enable_q <= '1;
      for (int k = 0; k < CHANNELS; k++) begin
        half_count_q[k]  <= '0;
        bits_left_q[k]   <= '0;
        first_half_q[k]  <= 1'b0;
        payload_q[k]     <= '0;
        ones_count_q[k]  <= '0;
        check_value_q[k] <= '0;
      end
    end else if (accept) begin
      if (restart) begin
        mode_q        <= MODE_HEADER;
        fail_count_q  <= '0;
        chan_enable_q <= '1;
        for (int k = 0; k < CHANNELS; k++) begin
          half_count_q[k]  <= '0;
          bits_left_q[k]   <= '0;
          first_half_q[k]  <= 1'b0;
          payload_q[k]     <= '0;
          ones_count_q[k]  <= '0;
          check_value_q[k] <= '0;
        end
      end else begin
        mode_q        <= mode_d;
        fail_count_q  <= fail_count_d;
        chan_enable_q <= chan_enable_d;
        half_count_q  <= half_count_d;
        bits_left_q   <= bits_left_d;
        first_half_q  <= first_half_d;
        payload_q     <= payload_d;
        ones_count_q  <= ones_count_d;
        check_value_q <= check_value_d;
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_q <= result_d;
      end else begin
        skid_q <= result_d;
      end
    end
  end

  // assertions
  `include "multichannel_manchester_frame_decoder_core_macros.svh"

  `MMFD_ASSERT(a_fail_count_tracks, fail_count_q == CHECK_W'($countones(~chan_enable_q)), "fail count out of step with disabled channels")
  `MMFD_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid holds a result while the output register is empty")
  `MMFD_ASSERT(a_quiet_result, (out_valid_q && out_q.status != STATUS_WORD) |-> (out_q.word == '0 && out_q.good_mask == '0), "word or mask set without a decoded word")
  `MMFD_ASSERT_NEXT(a_restart, accept && restart, mode_q == MODE_HEADER && (&chan_enable_q) && fail_count_q == '0, "channels did not restart after a result")

endmodule

`default_nettype wire

// ===== sim/multichannel_manchester_frame_decoder_core_test.sv =====
// testbench for multichannel_manchester_frame_decoder_core: random and directed ir frames,
// an independent per-channel decoder for predictions, random idling on both channels
// depends on mmfd_pkg and the core rtl
`default_nettype none

module multichannel_manchester_frame_decoder_core_test
  import mmfd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH       = 12;
  localparam int HDR_LEN   = 20;
  localparam int CHECK_LEN = 4;
  localparam int MAX_CYCLES = 400000;

  // shared decoder mode
  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_CHECK  = 2'd2
  } rx_mode_e;

  // how one channel behaves inside a generated frame
  typedef enum int {
    KIND_GOOD,
    KIND_BADCHECK,
    KIND_HDR_DROP,
    KIND_PAIR_DROP
  } chan_kind_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   channel_samples;
  logic                  out_valid_o;
  logic                  out_stall;
  logic [1:0]            status_o;
  logic [WORD_W-1:0]     word_o;
  logic [SAMPLE_W-1:0]   good_mask_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  multichannel_manchester_frame_decoder_core #(
    .CHANNELS(NCH),
    .HEADER_HALF_BITS(HDR_LEN),
    .CHECK_BITS(CHECK_LEN)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall_o),
    .channel_samples_i(channel_samples),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .status_o(status_o),
    .word_o(word_o),
    .good_mask_o(good_mask_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted decoder state
  logic [LEN_W-1:0]   len_reg;
  rx_mode_e           rx_mode;
  logic [3:0]         drop_count;
  logic               ch_on    [NCH];
  logic [5:0]         ch_half  [NCH];
  logic [5:0]         ch_left  [NCH];
  logic               ch_first [NCH];
  logic [WORD_W-1:0]  ch_word  [NCH];
  logic [5:0]         ch_ones  [NCH];
  logic [3:0]         ch_check [NCH];

  logic [SAMPLE_W-1:0] samples_to_send[$];
  result_t             predicted_results[$];

  logic [SAMPLE_W-1:0] frame_buf [0:199];
  int                  frame_n;
  logic                frame_has_good;

  logic idle_on;
  int   in_gap;
  int   out_gap;
  int   error_count;
  int   cycle_count;
  int   sent_count;
  int   frame_count;
  int   word_count;
  int   fail_count;

  function automatic logic [LEN_W-1:0] eff_len();
    if (len_reg < LEN_MIN) return LEN_MIN;
    if (len_reg > LEN_MAX) return LEN_MAX;
    return len_reg;
  endfunction

  function automatic void restart_channels();
    rx_mode    = MODE_HEADER;
    drop_count = '0;
    for (int k = 0; k < NCH; k++) begin
      ch_on[k]    = 1'b1;
      ch_half[k]  = '0;
      ch_left[k]  = '0;
      ch_first[k] = 1'b0;
      ch_word[k]  = '0;
      ch_ones[k]  = '0;
      ch_check[k] = '0;
    end
  endfunction

  function automatic void drop_channel(int k);
    ch_on[k]   = 1'b0;
    drop_count = drop_count + 4'd1;
  endfunction

  // advance every enabled channel by one half-bit and return the result
  function automatic result_t decode_samples(logic [SAMPLE_W-1:0] smp);
    rx_mode_e            cur;
    logic [SAMPLE_W-1:0] good;
    logic [WORD_W-1:0]   wd;
    logic                any_on;
    logic                s;
    logic [4:0]          pos;
    logic [5:0]          sh;
    result_t             r;
    cur    = rx_mode;
    good   = '0;
    wd     = '0;
    any_on = 1'b0;
    for (int k = 0; k < NCH; k++) begin
      if (ch_on[k]) begin
        s = smp[k];
        if (cur == MODE_DATA || cur == MODE_CHECK) begin
          // manchester pair handling
          if (ch_half[k] == 0) begin
            ch_half[k]  = 6'd1;
            ch_first[k] = s;
          end else begin
            ch_half[k] = '0;
            if (s != ch_first[k]) begin
              if (cur == MODE_DATA) begin
                pos = 5'(eff_len() - ch_left[k]);
                ch_word[k] = ch_word[k] | (WORD_W'(s) << pos);
                if (!ch_first[k]) ch_ones[k] = ch_ones[k] + 6'd1;
              end else begin
                sh = ch_left[k] - 6'd1;
                if (s && sh < CHECK_WEIGHTS) ch_check[k] = ch_check[k] + (4'd1 << sh);
              end
              ch_left[k] = ch_left[k] - 6'd1;
            end else begin
              drop_channel(k);
            end
          end
          // end of payload or check field
          if (ch_left[k] == 0) begin
            ch_half[k] = '0;
            if (cur == MODE_DATA) begin
              rx_mode     = MODE_CHECK;
              ch_left[k]  = 6'(CHECK_LEN);
              ch_check[k] = '0;
            end else begin
              if (4'(ch_check[k] + ch_ones[k][3:0]) == 4'd0) begin
                good[k] = 1'b1;
                wd      = ch_word[k];
              end
              ch_left[k] = eff_len();
            end
          end
        end else begin
          // header: a run of zero half-bits
          if (!s) begin
            ch_half[k] = ch_half[k] + 6'd1;
          end else begin
            drop_channel(k);
            ch_half[k] = '0;
          end
          if (ch_half[k] == 6'(HDR_LEN)) begin
            rx_mode     = MODE_DATA;
            ch_half[k]  = '0;
            ch_left[k]  = eff_len();
            ch_word[k]  = '0;
            ch_ones[k]  = '0;
            ch_check[k] = '0;
          end
        end
      end
    end
    for (int k = 0; k < NCH; k++) if (ch_on[k]) any_on = 1'b1;
    r.status    = STATUS_NONE;
    r.word      = '0;
    r.good_mask = '0;
    if (!any_on) begin
      restart_channels();
      r.status = STATUS_FAILED;
    end else if (good != 0) begin
      restart_channels();
      r.status    = STATUS_WORD;
      r.word      = wd;
      r.good_mask = good;
    end
    return r;
  endfunction

  // build one frame of half-bit samples in frame_buf
  task automatic build_frame(int len, bit all_good);
    chan_kind_e        kinds [NCH];
    int                sty;
    int                pick;
    int                body;
    int                ext;
    int                pos;
    logic [WORD_W-1:0] pay;
    logic [3:0]        chk;
    logic              b;
    sty = all_good ? 9 : $urandom_range(0, 9);
    frame_has_good = 1'b0;
    for (int k = 0; k < NCH; k++) begin
      pick = $urandom_range(0, 19);
      if (all_good) kinds[k] = KIND_GOOD;
      else if (sty == 0) kinds[k] = KIND_BADCHECK;
      else if (sty == 1) kinds[k] = pick[0] ? KIND_HDR_DROP : KIND_PAIR_DROP;
      else if (pick < 11) kinds[k] = KIND_GOOD;
      else if (pick < 15) kinds[k] = KIND_BADCHECK;
      else if (pick < 17) kinds[k] = KIND_HDR_DROP;
      else kinds[k] = KIND_PAIR_DROP;
      if (kinds[k] == KIND_GOOD) frame_has_good = 1'b1;
    end
    // with no good channel the failed checks run on for another payload length
    body    = 2 * len + 2 * CHECK_LEN;
    ext     = frame_has_good ? 0 : 2 * len;
    frame_n = HDR_LEN + body + ext;
    for (int t = 0; t < frame_n + 3; t++) frame_buf[t] = '0;
    for (int k = 0; k < NCH; k++) begin
      pick = $urandom_range(0, 7);
      pay  = (pick == 0) ? '0 : (pick == 1) ? '1 : WORD_W'($urandom());
      if (len < WORD_W) pay = pay & ((WORD_W'(1) << len) - 1);
      chk = 4'(-$countones(pay));
      if (kinds[k] == KIND_BADCHECK) chk = chk + 4'($urandom_range(1, 15));
      for (int i = 0; i < len; i++) begin
        frame_buf[HDR_LEN + 2*i][k]     = !pay[i];
        frame_buf[HDR_LEN + 2*i + 1][k] = pay[i];
      end
      for (int j = 0; j < CHECK_LEN; j++) begin
        frame_buf[HDR_LEN + 2*len + 2*j][k]     = !chk[CHECK_LEN-1-j];
        frame_buf[HDR_LEN + 2*len + 2*j + 1][k] = chk[CHECK_LEN-1-j];
      end
      for (int i = 0; i < ext / 2; i++) begin
        b = $urandom_range(0, 1);
        frame_buf[HDR_LEN + body + 2*i][k]     = !b;
        frame_buf[HDR_LEN + body + 2*i + 1][k] = b;
      end
      // broken channels: a one in the header or an equal pair, then noise
      pos = -1;
      if (kinds[k] == KIND_HDR_DROP) begin
        pos = $urandom_range(0, HDR_LEN - 1);
        frame_buf[pos][k] = 1'b1;
      end else if (kinds[k] == KIND_PAIR_DROP) begin
        pos = HDR_LEN + 2 * $urandom_range(0, (body + ext) / 2 - 1) + 1;
        frame_buf[pos][k] = frame_buf[pos-1][k];
      end
      if (pos >= 0)
        for (int t = pos + 1; t < frame_n; t++) frame_buf[t][k] = $urandom_range(0, 1);
    end
    // three all-ones samples bring any state back to a restart
    if (!frame_has_good) begin
      for (int t = frame_n; t < frame_n + 3; t++) frame_buf[t] = '1;
      frame_n = frame_n + 3;
    end
    frame_count++;
  endtask

  task automatic queue_frame_part(int from, int upto);
    for (int t = from; t < upto; t++) samples_to_send.push_back(frame_buf[t]);
  endtask

  task automatic queue_flush();
    repeat (3) samples_to_send.push_back('1);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (samples_to_send.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk_i);
  endtask

  // apb write of data_bits, upper data bits random
  task automatic write_len(logic [LEN_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DATA_BITS, 2'b00};
    pwdata  <= ($urandom() & ~32'h3f) | APB_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    len_reg = v;
  endtask

  // request driver with prediction at acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        predicted_results.push_back(decode_samples(channel_samples));
        sent_count++;
      end
      if (!in_valid || !in_stall_o) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          in_valid <= 1'b0;
          in_gap = $urandom_range(1, 9) - 1;
        end else if (samples_to_send.size() != 0) begin
          in_valid        <= 1'b1;
          channel_samples <= samples_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result status %0d word %h mask %h",
                   $time, status_o, word_o, good_mask_o);
          error_count++;
        end else begin
          exp_r = predicted_results.pop_front();
          if (status_o !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
            error_count++;
          end
          if (word_o !== exp_r.word) begin
            $display("%0t: word expected %h actual %h", $time, exp_r.word, word_o);
            error_count++;
          end
          if (good_mask_o !== exp_r.good_mask) begin
            $display("%0t: good_mask expected %h actual %h",
                     $time, exp_r.good_mask, good_mask_o);
            error_count++;
          end
          if (exp_r.status == STATUS_WORD) word_count++;
          if (exp_r.status == STATUS_FAILED) fail_count++;
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap--;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        out_gap = $urandom_range(1, 9) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus
  initial begin
    int rand_items;
    int pick;
    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    channel_samples = '0;
    out_stall       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    idle_on         = 1'b1;
    in_gap          = 0;
    out_gap         = 0;
    error_count     = 0;
    cycle_count     = 0;
    sent_count      = 0;
    frame_count     = 0;
    word_count      = 0;
    fail_count      = 0;
    rand_items      = 0;
    len_reg         = LEN_RESET;
    restart_channels();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extreme sample words straight after reset
    samples_to_send.push_back(12'h000);
    samples_to_send.push_back(12'hfff);
    samples_to_send.push_back(12'haaa);
    samples_to_send.push_back(12'h555);
    samples_to_send.push_back(12'h800);
    samples_to_send.push_back(12'h7ff);
    samples_to_send.push_back(12'h001);
    samples_to_send.push_back(12'hffe);
    queue_flush();
    wait_idle();

    // full-length frame at the reset length, every channel good
    build_frame(32, 1'b1);
    queue_frame_part(0, frame_n);
    wait_idle();

    // zero length acts as one
    write_len(6'd0);
    build_frame(1, 1'b1);
    queue_frame_part(0, frame_n);
    wait_idle();

    // lengths above the limit act as 32
    write_len(6'd63);
    build_frame(32, 1'b1);
    queue_frame_part(0, frame_n);
    wait_idle();
    write_len(6'd33);
    build_frame(32, 1'b0);
    queue_frame_part(0, frame_n);
    wait_idle();

    // length changed in the middle of a payload
    write_len(6'd4);
    build_frame(4, 1'b1);
    queue_frame_part(0, HDR_LEN + 4);
    wait_idle();
    write_len(6'd6);
    queue_frame_part(HDR_LEN + 4, frame_n);
    queue_flush();
    wait_idle();

    // random frames, mostly short, length changed every few frames
    while (rand_items < 120) begin
      if (frame_count % 3 == 0) begin
        wait_idle();
        pick = $urandom_range(0, 5);
        write_len(pick == 0 ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 12)));
      end
      if ($urandom_range(0, 4) == 0) begin
        pick = $urandom_range(1, 6);
        repeat (pick) samples_to_send.push_back(12'($urandom_range(0, 4095)));
        queue_flush();
        rand_items += pick + 3;
      end
      build_frame(int'(eff_len()), 1'b0);
      queue_frame_part(0, frame_n);
      rand_items += frame_n;
      if (rand_items >= 80) idle_on = 1'b0;
    end

    wait_idle();
    repeat (5) @(posedge clk_i);
    $display("covered %0d sample words in %0d frames at lengths 1 to 32", sent_count, frame_count);
    $display("results: %0d decoded words, %0d total failures", word_count, fail_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/mmfd_pkg.sv
rtl/multichannel_manchester_frame_decoder_core.sv
sim/multichannel_manchester_frame_decoder_core_test.sv
